### design/red_pkg.sv
// Package for the rounded Euclidean distance core.
// Holds field widths, the square-root stage record and the one-step root function.
// Depends on nothing; used by design/rounded_euclidean_distance_core.sv.

package red_pkg;

    // Field and datapath widths.
    localparam int COORD_W    = 16;                  // input coordinate
    localparam int DIFF_W     = 16;                  // |a - b| of two coordinates
    localparam int SQ_W       = 2 * DIFF_W;          // one square
    localparam int SUM_W      = SQ_W + 2;            // dx*dx + dy*dy, rounded up to even
    localparam int ROOT_W     = SUM_W / 2;           // integer square root
    localparam int REM_W      = ROOT_W + 1;          // remainder never exceeds 2 * root
    localparam int SQRT_STEPS = ROOT_W;              // one root bit per stage
    localparam int DIST_W     = 17;                  // result field

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W  = 4 * COORD_W;
    localparam int M_TDATA_W  = ((DIST_W + 7) / 8) * 8;

    // One stage of the digit-by-digit square root.
    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  rad;    // radicand bits not yet consumed, top-aligned
        logic [REM_W-1:0]  rem;    // partial remainder
        logic [ROOT_W-1:0] root;   // partial root
    } sqrt_stage_t;

    // One step of the restoring square root: bring down two radicand bits,
    // try the next root bit as one, and keep it if the trial fits.
    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t cur);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             fits;
        sqrt_stage_t      nxt;
        rem_sh    = {cur.rem, cur.rad[SUM_W-1 -: 2]};
        trial     = {1'b0, cur.root, 2'b01};
        fits      = (rem_sh >= trial);
        nxt.valid = cur.valid;
        nxt.rad   = {cur.rad[SUM_W-3:0], 2'b00};
        nxt.rem   = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        nxt.root  = {cur.root[ROOT_W-2:0], fits};
        return nxt;
    endfunction

endpackage

### design/rounded_euclidean_distance_core.sv
// Rounded Euclidean distance core: streaming pipeline from two points to a distance.
// Depends on red_pkg for widths, the root stage record and the root step function.

// The core takes one point pair per clock while it is not stalled and returns
// floor(sqrt(dx^2 + dy^2) + 0.5) for each pair, in order. An item goes through 21
// register stages: absolute differences, two 16 by 16 squares, the 34-bit sum, 17
// stages of the bit-serial square root (one root bit per stage), and a final stage
// that rounds up when the remainder exceeds the root and drives m_tvalid.
// The sustained rate is one item per cycle while m_tready is high.
// When the output item is not taken the whole pipeline holds, so s_tready drops
// only while a finished item waits at the output and the sink is not ready.
// The core keeps no state between items; reset only clears the valid bits.

module rounded_euclidean_distance_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Fields from bit 0 up: first_x[15:0], first_y[31:16],
    // second_x[47:32], second_y[63:48], each signed.
    input  logic [red_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: distance[16:0], zero padding [23:17].
    output logic [red_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    // Pipeline advance: all stages move together unless the output item is stuck.
    logic advance;
    logic out_valid_reg;
    assign advance  = m_tready || !out_valid_reg;
    assign s_tready = advance;

    // Input field unpacking.
    logic signed [red_pkg::COORD_W-1:0] first_x, first_y, second_x, second_y;
    assign first_x  = s_tdata[0*red_pkg::COORD_W +: red_pkg::COORD_W];
    assign first_y  = s_tdata[1*red_pkg::COORD_W +: red_pkg::COORD_W];
    assign second_x = s_tdata[2*red_pkg::COORD_W +: red_pkg::COORD_W];
    assign second_y = s_tdata[3*red_pkg::COORD_W +: red_pkg::COORD_W];

    // Stage 1: absolute coordinate differences.
    logic                              diff_valid_reg, diff_valid_next;
    logic [red_pkg::DIFF_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic signed [red_pkg::COORD_W:0]  raw_dx, raw_dy;

    always_comb begin
        raw_dx = {first_x[red_pkg::COORD_W-1], first_x}
               - {second_x[red_pkg::COORD_W-1], second_x};
        raw_dy = {first_y[red_pkg::COORD_W-1], first_y}
               - {second_y[red_pkg::COORD_W-1], second_y};
        diff_valid_next = s_tvalid;
        dx_next = raw_dx[red_pkg::COORD_W] ? red_pkg::DIFF_W'(-raw_dx)
                                           : red_pkg::DIFF_W'(raw_dx);
        dy_next = raw_dy[red_pkg::COORD_W] ? red_pkg::DIFF_W'(-raw_dy)
                                           : red_pkg::DIFF_W'(raw_dy);
    end

    // Stage 2: the two squares, one multiplier each.
    logic                       sq_valid_reg, sq_valid_next;
    logic [red_pkg::SQ_W-1:0]   dx_sq_reg, dx_sq_next, dy_sq_reg, dy_sq_next;

    always_comb begin
        sq_valid_next = diff_valid_reg;
        dx_sq_next    = dx_reg * dx_reg;
        dy_sq_next    = dy_reg * dy_reg;
    end

    // Stage 3: the exact sum, loaded as the first square-root stage.
    // Stages 4 to 20: one root bit each.
    red_pkg::sqrt_stage_t sqrt_reg  [0:red_pkg::SQRT_STEPS];
    red_pkg::sqrt_stage_t sqrt_next [0:red_pkg::SQRT_STEPS];

    always_comb begin
        sqrt_next[0].valid = sq_valid_reg;
        sqrt_next[0].rad   = red_pkg::SUM_W'(dx_sq_reg) + red_pkg::SUM_W'(dy_sq_reg);
        sqrt_next[0].rem   = '0;
        sqrt_next[0].root  = '0;
        for (int k = 0; k < red_pkg::SQRT_STEPS; k++) begin
            sqrt_next[k+1] = red_pkg::sqrt_step(sqrt_reg[k]);
        end
    end

    // Stage 21: round half up when the remainder exceeds the root.
    logic                        out_valid_next;
    logic [red_pkg::DIST_W-1:0]  distance_reg, distance_next;
    red_pkg::sqrt_stage_t        last;

    always_comb begin
        last           = sqrt_reg[red_pkg::SQRT_STEPS];
        out_valid_next = last.valid;
        distance_next  = red_pkg::DIST_W'(last.root)
                       + red_pkg::DIST_W'(red_pkg::REM_W'(last.root) < last.rem);
    end

    // Valid bits, cleared by reset. The root stages load as whole records here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k <= red_pkg::SQRT_STEPS; k++) begin
                sqrt_reg[k].valid <= 1'b0;
            end
        end else if (advance) begin
            diff_valid_reg <= diff_valid_next;
            sq_valid_reg   <= sq_valid_next;
            out_valid_reg  <= out_valid_next;
            for (int k = 0; k <= red_pkg::SQRT_STEPS; k++) begin
                sqrt_reg[k] <= sqrt_next[k];
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            dx_sq_reg    <= dx_sq_next;
            dy_sq_reg    <= dy_sq_next;
            distance_reg <= distance_next;
        end
    end

    // Output item.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = red_pkg::M_TDATA_W'(distance_reg);

endmodule
